FILE: sv/hbs_pkg.sv
package hbs_pkg;

  // Grid geometry
  localparam int MAX_SIDE = 1024;
  localparam int CFG_W    = 11;
  localparam int COL_W    = $clog2(MAX_SIDE);
  // Input row counter reaches side+1, past the grid, while the window drains
  localparam int SIDE_W   = $clog2(MAX_SIDE + 2);
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 10;
  localparam int RES_W    = 16;

  // Neighborhood sum of up to nine bytes, and the rounded numerator sum*512 + count
  localparam int SUM_W    = 12;
  localparam int NUM_W    = SUM_W + 9;

  // Reciprocals for the divisors 2*6 and 2*9
  localparam int REC_SHIFT = 26;
  localparam int REC_DIV6  = ((2 ** REC_SHIFT) + 11) / 12;
  localparam int REC_DIV9  = ((2 ** REC_SHIFT) + 17) / 18;
  localparam int REC_W     = $clog2(REC_DIV6 + 1);

  // Request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  // Number of in-grid samples in a neighborhood
  typedef enum logic [1:0] {
    CNT1 = 2'd0,
    CNT4 = 2'd1,
    CNT6 = 2'd2,
    CNT9 = 2'd3
  } cnt_t;

  typedef struct packed {
    logic              req_type;
    logic [BYTE_W-1:0] height_byte;
  } in_t;

  typedef struct packed {
    logic [RES_W-1:0] smoothed_height;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             last_of_map;
  } out_t;

  // Window stage control, one per kept transaction
  typedef struct packed {
    logic              valid;
    logic [COL_W-1:0]  col;
    logic              row_ge1;
    logic              row_ge2;
    logic [BYTE_W-1:0] nw;
    logic              produce;
    logic              top;
    logic              bot;
    logic              lft;
    logic              rgt;
    logic [COL_W-1:0]  out_r;
    logic [COL_W-1:0]  out_c;
    logic              last;
  } ctl_t;

  // Sum stage contents
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    cnt_t             cnt;
    logic [COL_W-1:0] out_r;
    logic [COL_W-1:0] out_c;
    logic             last;
  } sum_t;

endpackage

FILE: sv/heightmap_box3x3_smooth.sv
// Edge-normalized 3x3 box filter over a square height map streamed in raster
// order. Each sample's result is the rounded Q8.8 mean of its in-grid neighbors
// and leaves side_length+1 transactions after the sample; after the last sample
// of a map, send side_length+1 flush transactions to drain it. The block takes
// one transaction per clock cycle unless the output stalls; a result passes
// the window, sum and result registers after the transaction that completes
// its window. That rate is set by the single read and single write port of
// each line store, used once per transaction. The line stores need no clearing
// after reset. Write side_length only while idle; a write restarts the map.
module heightmap_box3x3_smooth (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [hbs_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  hbs_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output hbs_pkg::out_t             out_data
);

  logic                      advance;
  logic                      rd_en;
  logic [hbs_pkg::COL_W-1:0] rd_addr;
  hbs_pkg::ctl_t             ctl;
  hbs_pkg::sum_t             sum_st;

  // Move the whole pipeline whenever the result register can take a new value
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign cfg_ready = 1'b1;

  hbs_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_data  (in_data),
    .advance  (advance),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .ctl      (ctl)
  );

  hbs_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(advance),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .ctl    (ctl),
    .sum_out(sum_st)
  );

  hbs_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .sum_in   (sum_st),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

FILE: sv/hbs_ram.sv
module hbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address write, held while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/hbs_seq.sv
module hbs_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic [hbs_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  input  hbs_pkg::in_t              in_data,
  input  logic                      advance,
  output logic                      rd_en,
  output logic [hbs_pkg::COL_W-1:0] rd_addr,
  output hbs_pkg::ctl_t             ctl
);

  logic [hbs_pkg::SIDE_W-1:0] side_r;
  logic [hbs_pkg::SIDE_W-1:0] side_nxt;
  logic [hbs_pkg::SIDE_W-1:0] in_row_r;
  logic [hbs_pkg::COL_W-1:0]  in_col_r;
  logic [hbs_pkg::COL_W-1:0]  out_r_r;
  logic [hbs_pkg::COL_W-1:0]  out_c_r;
  hbs_pkg::ctl_t              ctl_r;

  logic accept;
  logic in_grid;
  logic drop;
  logic keep;
  logic produce;
  logic col_end;
  logic oc_end;
  logic or_end;
  logic last;

  // Clamp the written side into the supported range
  always_comb begin
    if (cfg_data == '0) begin
      side_nxt = hbs_pkg::SIDE_W'(1);
    end else if (32'(cfg_data) > 32'(hbs_pkg::MAX_SIDE)) begin
      side_nxt = hbs_pkg::SIDE_W'(hbs_pkg::MAX_SIDE);
    end else begin
      side_nxt = hbs_pkg::SIDE_W'(cfg_data);
    end
  end

  // Classify the incoming transaction
  assign accept  = in_valid && advance;
  assign in_grid = in_row_r < side_r;
  assign drop    = (in_data.req_type == hbs_pkg::REQ_FLUSH) && in_grid;
  assign keep    = accept && !drop;
  assign produce = (in_row_r >= hbs_pkg::SIDE_W'(2)) ||
                   ((in_row_r == hbs_pkg::SIDE_W'(1)) && (in_col_r != '0));
  assign col_end = (hbs_pkg::SIDE_W'(in_col_r) + hbs_pkg::SIDE_W'(1)) == side_r;
  assign oc_end  = (hbs_pkg::SIDE_W'(out_c_r) + hbs_pkg::SIDE_W'(1)) == side_r;
  assign or_end  = (hbs_pkg::SIDE_W'(out_r_r) + hbs_pkg::SIDE_W'(1)) == side_r;
  assign last    = produce && oc_end && or_end;

  // Side register and raster positions; a config write restarts the map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r   <= hbs_pkg::SIDE_W'(hbs_pkg::MAX_SIDE);
      in_row_r <= '0;
      in_col_r <= '0;
      out_r_r  <= '0;
      out_c_r  <= '0;
    end else if (cfg_valid) begin
      side_r   <= side_nxt;
      in_row_r <= '0;
      in_col_r <= '0;
      out_r_r  <= '0;
      out_c_r  <= '0;
    end else if (keep) begin
      if (last) begin
        in_row_r <= '0;
        in_col_r <= '0;
        out_r_r  <= '0;
        out_c_r  <= '0;
      end else begin
        if (col_end) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + hbs_pkg::SIDE_W'(1);
        end else begin
          in_col_r <= in_col_r + hbs_pkg::COL_W'(1);
        end
        if (produce) begin
          if (oc_end) begin
            out_c_r <= '0;
            out_r_r <= out_r_r + hbs_pkg::COL_W'(1);
          end else begin
            out_c_r <= out_c_r + hbs_pkg::COL_W'(1);
          end
        end
      end
    end
  end

  // Window stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (advance) begin
      ctl_r.valid <= keep;
    end
  end

  // Window stage payload
  always_ff @(posedge clk) begin
    if (keep) begin
      ctl_r.col     <= in_col_r;
      ctl_r.row_ge1 <= in_row_r != '0;
      ctl_r.row_ge2 <= in_row_r >= hbs_pkg::SIDE_W'(2);
      ctl_r.nw      <= in_grid ? in_data.height_byte : '0;
      ctl_r.produce <= produce;
      ctl_r.top     <= out_r_r != '0;
      ctl_r.bot     <= !or_end;
      ctl_r.lft     <= out_c_r != '0;
      ctl_r.rgt     <= !oc_end;
      ctl_r.out_r   <= out_r_r;
      ctl_r.out_c   <= out_c_r;
      ctl_r.last    <= last;
    end
  end

  assign rd_en   = keep;
  assign rd_addr = in_col_r;
  assign ctl     = ctl_r;

endmodule

FILE: sv/hbs_window.sv
module hbs_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  logic                      rd_en,
  input  logic [hbs_pkg::COL_W-1:0] rd_addr,
  input  hbs_pkg::ctl_t             ctl,
  output hbs_pkg::sum_t             sum_out
);

  logic [hbs_pkg::BYTE_W-1:0] up_dout;
  logic [hbs_pkg::BYTE_W-1:0] mid_dout;
  logic [hbs_pkg::BYTE_W-1:0] up;
  logic [hbs_pkg::BYTE_W-1:0] mid;
  logic                       fwd_r;
  logic [hbs_pkg::BYTE_W-1:0] fwd_up_r;
  logic [hbs_pkg::BYTE_W-1:0] fwd_mid_r;
  logic [hbs_pkg::BYTE_W-1:0] taps_r   [3][3];
  logic [hbs_pkg::BYTE_W-1:0] taps_nxt [3][3];
  logic [hbs_pkg::SUM_W-1:0]  sum_nxt;
  hbs_pkg::cnt_t              cnt_nxt;
  hbs_pkg::sum_t              sum_r;
  logic                       step;
  logic                       wr_hit;

  assign step   = ctl.valid && advance;
  assign wr_hit = ctl.valid && (ctl.col == rd_addr);

  // Line stores: upper takes the old middle, middle takes the new sample
  hbs_ram #(
    .WIDTH(hbs_pkg::BYTE_W),
    .DEPTH(hbs_pkg::MAX_SIDE)
  ) u_upper (
    .clk  (clk),
    .we   (step),
    .waddr(ctl.col),
    .wdata(mid),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(up_dout)
  );

  hbs_ram #(
    .WIDTH(hbs_pkg::BYTE_W),
    .DEPTH(hbs_pkg::MAX_SIDE)
  ) u_middle (
    .clk  (clk),
    .we   (step),
    .waddr(ctl.col),
    .wdata(ctl.nw),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(mid_dout)
  );

  // Forward a write that lands on the address read in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_up_r  <= mid;
      fwd_mid_r <= ctl.nw;
    end
  end

  // Mask store reads of rows not yet streamed
  assign up  = ctl.row_ge2 ? (fwd_r ? fwd_up_r : up_dout) : '0;
  assign mid = ctl.row_ge1 ? (fwd_r ? fwd_mid_r : mid_dout) : '0;

  // Shift the window one column
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      taps_nxt[k][0] = taps_r[k][1];
      taps_nxt[k][1] = taps_r[k][2];
    end
    taps_nxt[0][2] = up;
    taps_nxt[1][2] = mid;
    taps_nxt[2][2] = ctl.nw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          taps_r[k][j] <= '0;
        end
      end
    end else if (step) begin
      taps_r <= taps_nxt;
    end
  end

  // Sum the in-grid taps
  always_comb begin
    logic row_ok;
    sum_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      row_ok = (k == 0) ? ctl.top : ((k == 2) ? ctl.bot : 1'b1);
      if (row_ok) begin
        if (ctl.lft) begin
          sum_nxt = sum_nxt + hbs_pkg::SUM_W'(taps_nxt[k][0]);
        end
        sum_nxt = sum_nxt + hbs_pkg::SUM_W'(taps_nxt[k][1]);
        if (ctl.rgt) begin
          sum_nxt = sum_nxt + hbs_pkg::SUM_W'(taps_nxt[k][2]);
        end
      end
    end
  end

  // Classify the neighborhood size
  always_comb begin
    if (!(ctl.top || ctl.bot)) begin
      cnt_nxt = hbs_pkg::CNT1;
    end else if ((ctl.top && ctl.bot) && (ctl.lft && ctl.rgt)) begin
      cnt_nxt = hbs_pkg::CNT9;
    end else if ((ctl.top && ctl.bot) || (ctl.lft && ctl.rgt)) begin
      cnt_nxt = hbs_pkg::CNT6;
    end else begin
      cnt_nxt = hbs_pkg::CNT4;
    end
  end

  // Sum stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r.valid <= 1'b0;
    end else if (advance) begin
      sum_r.valid <= ctl.valid && ctl.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      sum_r.sum   <= sum_nxt;
      sum_r.cnt   <= cnt_nxt;
      sum_r.out_r <= ctl.out_r;
      sum_r.out_c <= ctl.out_c;
      sum_r.last  <= ctl.last;
    end
  end

  assign sum_out = sum_r;

endmodule

FILE: sv/hbs_norm.sv
module hbs_norm (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  hbs_pkg::sum_t sum_in,
  output logic          out_valid,
  output hbs_pkg::out_t out_data
);

  logic [hbs_pkg::NUM_W-1:0]               num;
  logic [hbs_pkg::REC_W-1:0]               rec;
  logic [hbs_pkg::NUM_W+hbs_pkg::REC_W-1:0] prod;
  logic [hbs_pkg::RES_W-1:0]               res_nxt;
  logic                                    out_valid_r;
  hbs_pkg::out_t                           out_data_r;

  // Rounded numerator sum*512 + count for the divisors that are not powers of two
  assign num = {sum_in.sum, 9'd0} +
               hbs_pkg::NUM_W'((sum_in.cnt == hbs_pkg::CNT6) ? 4'd6 : 4'd9);
  assign rec = (sum_in.cnt == hbs_pkg::CNT6) ?
               hbs_pkg::REC_W'(hbs_pkg::REC_DIV6) : hbs_pkg::REC_W'(hbs_pkg::REC_DIV9);
  assign prod = (hbs_pkg::NUM_W + hbs_pkg::REC_W)'(num) *
                (hbs_pkg::NUM_W + hbs_pkg::REC_W)'(rec);

  // Select the mean; counts of one and four reduce to shifts
  always_comb begin
    unique case (sum_in.cnt) inside
      hbs_pkg::CNT1: res_nxt = hbs_pkg::RES_W'({sum_in.sum, 8'd0});
      hbs_pkg::CNT4: res_nxt = hbs_pkg::RES_W'({sum_in.sum, 6'd0});
      hbs_pkg::CNT6,
      hbs_pkg::CNT9: res_nxt = hbs_pkg::RES_W'(prod >> hbs_pkg::REC_SHIFT);
      default:       res_nxt = '0;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= sum_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && sum_in.valid) begin
      out_data_r.smoothed_height <= res_nxt;
      out_data_r.out_row         <= hbs_pkg::POS_W'(sum_in.out_r);
      out_data_r.out_col         <= hbs_pkg::POS_W'(sum_in.out_c);
      out_data_r.last_of_map     <= sum_in.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: sv/hbs_checker.sv
module hbs_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input hbs_pkg::out_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Input is taken whenever the result register is free or draining
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow result register");

  // The final sample of a square map sits on the diagonal
  a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_of_map |-> out_data.out_row == out_data.out_col)
    else $error("last result off the diagonal");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind heightmap_box3x3_smooth hbs_checker u_hbs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

FILE: test/tb_heightmap_box3x3_smooth.sv
module tb_heightmap_box3x3_smooth;
  timeunit 1ns;
  timeprecision 1ps;

  import hbs_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1450;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Items waiting for the driver, and means still owed by the block
  in_t height_stream[$];
  out_t expected_means[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int random_items = 0;
  int hold_left = 0;
  bit held_once = 1'b0;
  int quiet_cycles = 0;

  // Filter state mirrored from the block
  logic [CFG_W-1:0] side_reg;
  logic [20:0] take_pos;
  logic [BYTE_W-1:0] upper_line[MAX_SIDE];
  logic [BYTE_W-1:0] middle_line[MAX_SIDE];
  logic [BYTE_W-1:0] win[3][3];

  heightmap_box3x3_smooth uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Advance the window by one transaction; return 1 when it yields a mean
  function automatic bit smooth_sample(input in_t item, output out_t res);
    int unsigned s, total, t, row, col, p, r, c, sum, count;
    logic [BYTE_W-1:0] up, mid, nw;
    bit top, bot, lft, rgt;
    res = '0;
    s = (side_reg == 0) ? 1 : ((side_reg > MAX_SIDE) ? MAX_SIDE : side_reg);
    total = s * s;
    t = take_pos;
    // Flush ticks are dropped while samples are still due
    if (item.req_type == REQ_FLUSH && t < total) return 1'b0;
    row = t / s;
    col = t % s;
    up = (row >= 2) ? upper_line[col] : '0;
    mid = (row >= 1) ? middle_line[col] : '0;
    nw = (t < total) ? item.height_byte : '0;
    upper_line[col] = mid;
    middle_line[col] = nw;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = nw;
    take_pos = 21'(t + 1);
    if (t < s + 1) return 1'b0;

    // Mean over the in-grid part of the neighborhood
    p = t - s - 1;
    r = p / s;
    c = p % s;
    top = r > 0;
    bot = r + 1 < s;
    lft = c > 0;
    rgt = c + 1 < s;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      if ((k != 0 || top) && (k != 2 || bot))
        sum += (lft ? int'(win[k][0]) : 0) + int'(win[k][1]) + (rgt ? int'(win[k][2]) : 0);
    end
    count = (1 + int'(top) + int'(bot)) * (1 + int'(lft) + int'(rgt));
    res.smoothed_height = RES_W'((sum * 512 + count) / (2 * count));
    res.out_row = POS_W'(r);
    res.out_col = POS_W'(c);
    res.last_of_map = (p + 1 == total);
    if (res.last_of_map) take_pos = '0;
    return 1'b1;
  endfunction

  // Drive the sample stream
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (height_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= height_stream.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel; hold it off once for a long stretch to back up the block
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held_once && height_stream.size() > 300) begin
      out_ready <= 1'b0;
      hold_left <= 600;
      held_once <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check results, then track config and input transactions
  always @(posedge clk) begin
    out_t want, fresh;
    if (!rst_n) begin
      side_reg = CFG_W'(MAX_SIDE);
      take_pos = '0;
      win = '{default: '0};
    end else begin
      if (out_valid && out_ready) begin
        if (expected_means.size() == 0) begin
          $error("result with nothing expected: row %0d col %0d",
                 out_data.out_row, out_data.out_col);
          mismatches++;
        end else begin
          want = expected_means.pop_front();
          if (out_data.smoothed_height !== want.smoothed_height) begin
            $error("smoothed_height: expected %0d, got %0d",
                   want.smoothed_height, out_data.smoothed_height);
            mismatches++;
          end
          if (out_data.out_row !== want.out_row) begin
            $error("out_row: expected %0d, got %0d", want.out_row, out_data.out_row);
            mismatches++;
          end
          if (out_data.out_col !== want.out_col) begin
            $error("out_col: expected %0d, got %0d", want.out_col, out_data.out_col);
            mismatches++;
          end
          if (out_data.last_of_map !== want.last_of_map) begin
            $error("last_of_map: expected %0d, got %0d",
                   want.last_of_map, out_data.last_of_map);
            mismatches++;
          end
        end
      end
      // A side write restarts the map; stores and taps keep their contents
      if (cfg_valid && cfg_ready) begin
        side_reg = cfg_data;
        take_pos = '0;
      end
      if (in_valid && in_ready) begin
        if (smooth_sample(in_data, fresh)) expected_means.push_back(fresh);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL heightmap_box3x3_smooth");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [BYTE_W-1:0] rand_height();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  function automatic void add_item(input logic kind, input logic [BYTE_W-1:0] b,
                                   input bit counted);
    in_t item;
    item.req_type = kind;
    item.height_byte = b;
    height_stream.push_back(item);
    if (counted) random_items++;
  endfunction

  // Queue one map: samples with stray flush ticks, then the drain;
  // a cut-short map stops partway and is abandoned by the next side write
  task automatic queue_map(input int s, input bit cut_short);
    int n;
    n = cut_short ? $urandom_range(s * s - 1, 1) : s * s;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(19) == 0) add_item(REQ_FLUSH, rand_height(), 1'b0);
      add_item(REQ_SAMPLE, rand_height(), 1'b1);
    end
    if (!cut_short) begin
      for (int k = 0; k <= s; k++) begin
        if ($urandom_range(3) == 0) add_item(REQ_SAMPLE, rand_height(), 1'b1);
        else add_item(REQ_FLUSH, rand_height(), 1'b1);
      end
    end
  endtask

  // Let the block drain, then wait out its pipeline
  task automatic wait_idle();
    while (height_stream.size() != 0 || in_valid || expected_means.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_side(input logic [CFG_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_side();
    case ($urandom_range(15))
      0: return 0;
      1: return 1;
      2: return $urandom_range(40, 13);
      default: return $urandom_range(12, 2);
    endcase
  endfunction

  initial begin
    int s;
    bit first;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Side 0 acts as 1: stray flush, lone sample, sample during drain
    write_side(11'd0);
    add_item(REQ_FLUSH, 8'h3C, 1'b0);
    add_item(REQ_SAMPLE, 8'hFF, 1'b0);
    add_item(REQ_SAMPLE, 8'hA5, 1'b0);
    add_item(REQ_FLUSH, 8'h00, 1'b0);

    // Side 2: every sample is a corner
    write_side(11'd2);
    add_item(REQ_SAMPLE, 8'hFF, 1'b0);
    add_item(REQ_SAMPLE, 8'hFF, 1'b0);
    add_item(REQ_FLUSH, 8'h00, 1'b0);
    add_item(REQ_SAMPLE, 8'hFF, 1'b0);
    add_item(REQ_SAMPLE, 8'hFE, 1'b0);
    add_item(REQ_FLUSH, 8'h00, 1'b0);
    add_item(REQ_SAMPLE, 8'h01, 1'b0);
    add_item(REQ_FLUSH, 8'hFF, 1'b0);

    // Side 3: corners, edges and one interior sample
    write_side(11'd3);
    for (int k = 0; k < 9; k++) add_item(REQ_SAMPLE, (k % 2 != 0) ? 8'hFF : 8'h00, 1'b0);
    for (int k = 0; k < 4; k++) add_item(REQ_FLUSH, 8'h00, 1'b0);

    // Random maps over the four idling phases
    random_items = 0;
    first = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      s = first ? 24 : pick_side();
      wait_idle();
      case (random_items * 4 / RANDOM_ITEMS)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 80; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 80; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      write_side(CFG_W'(s));
      repeat (first ? 1 : $urandom_range(3, 1)) queue_map(s, 1'b0);
      if (s >= 2 && $urandom_range(3) == 0) queue_map(s, 1'b1);
      first = 1'b0;
    end

    // Oversized side clamps to the largest grid; run past the first row
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_side(11'd2047);
    for (int k = 0; k < MAX_SIDE + 16; k++) add_item(REQ_SAMPLE, rand_height(), 1'b0);
    write_side(CFG_W'(MAX_SIDE));
    for (int k = 0; k < 30; k++) add_item(REQ_SAMPLE, rand_height(), 1'b0);

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS heightmap_box3x3_smooth");
    end else begin
      $display("FAIL heightmap_box3x3_smooth");
    end
    $finish;
  end

endmodule
